[design/nnls_pkg.sv]
// Shared types and constants for the nearest-neighbor list selector.
package nnls_pkg;

	// Fixed field widths
	localparam int NODE_W   = 10;
	localparam int RANK_W   = 5;
	localparam int DEPTH_W  = 6;
	localparam int COUNT_W  = 11;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 11;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REQUESTED_DEPTH = 4'd0,
		REG_NODE_COUNT      = 4'd1
	} cfg_reg_t;

	// Controller state
	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	// Per-list chain control
	typedef struct packed {
		logic load;   // insert the candidate this cycle
		logic pop;    // shift every entry one cell toward the head
		logic clear;  // drop every entry
	} cell_ctl_t;

endpackage

[design/nnls_if.sv]
// Stream and configuration channel interfaces of the neighbor list selector.
interface nnls_in_if #(
	parameter int DIST_BITS = 32
);
	logic                        valid;
	logic                        ready;
	logic [nnls_pkg::NODE_W-1:0] row_node;
	logic [nnls_pkg::NODE_W-1:0] column_node;
	logic [DIST_BITS-1:0]        distance;
	logic                        last_in_row;

	modport source (output valid, row_node, column_node, distance, last_in_row, input ready);
	modport sink   (input valid, row_node, column_node, distance, last_in_row, output ready);
endinterface

interface nnls_out_if;
	logic                        valid;
	logic                        ready;
	logic [nnls_pkg::NODE_W-1:0] list_node;
	logic [nnls_pkg::RANK_W-1:0] rank;
	logic [nnls_pkg::NODE_W-1:0] near_any;
	logic [nnls_pkg::NODE_W-1:0] near_non_depot;
	logic                        last;

	modport source (output valid, list_node, rank, near_any, near_non_depot, last, input ready);
	modport sink   (input valid, list_node, rank, near_any, near_non_depot, last, output ready);
endinterface

interface nnls_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [nnls_pkg::CFG_IDX_W-1:0]  index;
	logic [nnls_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[design/nnls_cell.sv]
// One slot of a sorted candidate chain: compare, hold, take left or right neighbor.
module nnls_cell #(
	parameter int DIST_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  nnls_pkg::cell_ctl_t         ctl,
	input  logic [DIST_BITS-1:0]        cand_dist,
	input  logic [nnls_pkg::NODE_W-1:0] cand_idx,
	input  logic                        left_ahead,
	input  logic [DIST_BITS-1:0]        left_dist,
	input  logic [nnls_pkg::NODE_W-1:0] left_idx,
	input  logic                        left_valid,
	input  logic [DIST_BITS-1:0]        right_dist,
	input  logic [nnls_pkg::NODE_W-1:0] right_idx,
	input  logic                        right_valid,
	output logic                        ahead,
	output logic [DIST_BITS-1:0]        dist_q,
	output logic [nnls_pkg::NODE_W-1:0] idx_q,
	output logic                        valid_q
);

	logic take_left;
	logic take_cand;

	// Candidate ranks ahead of this entry (empty slots lose to anything)
	assign ahead = !valid_q || (cand_dist < dist_q) ||
		((cand_dist == dist_q) && (cand_idx < idx_q));

	assign take_left = ctl.load && ahead && left_ahead;
	assign take_cand = ctl.load && ahead && !left_ahead;

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.pop) begin
			valid_q <= right_valid;
		end else if (take_left) begin
			valid_q <= left_valid;
		end else if (take_cand) begin
			valid_q <= 1'b1;
		end
	end

	// Entry payload
	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			dist_q <= right_dist;
			idx_q  <= right_idx;
		end else if (take_left) begin
			dist_q <= left_dist;
			idx_q  <= left_idx;
		end else if (take_cand) begin
			dist_q <= cand_dist;
			idx_q  <= cand_idx;
		end
	end

endmodule

[design/nnls_chain.sv]
// Sorted candidate list built as a row of cells, head at cell 0.
module nnls_chain #(
	parameter int DEPTH     = 32,
	parameter int DIST_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  nnls_pkg::cell_ctl_t         ctl,
	input  logic [DIST_BITS-1:0]        cand_dist,
	input  logic [nnls_pkg::NODE_W-1:0] cand_idx,
	output logic [nnls_pkg::NODE_W-1:0] head_idx,
	output logic                        head_valid
);

	logic [DIST_BITS-1:0]        ent_dist  [DEPTH+1];
	logic [nnls_pkg::NODE_W-1:0] ent_idx   [DEPTH+1];
	logic                        ent_valid [DEPTH+1];
	logic                        ahead     [DEPTH];

	// Empty slot past the tail feeds the shift toward the head
	assign ent_dist[DEPTH]  = '0;
	assign ent_idx[DEPTH]   = '0;
	assign ent_valid[DEPTH] = 1'b0;

	// Build the row; cell 0 has no left neighbor
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                        lb;
		logic [DIST_BITS-1:0]        ld;
		logic [nnls_pkg::NODE_W-1:0] li;
		logic                        lv;

		if (i == 0) begin : g_head
			assign lb = 1'b0;
			assign ld = '0;
			assign li = '0;
			assign lv = 1'b0;
		end else begin : g_body
			assign lb = ahead[i-1];
			assign ld = ent_dist[i-1];
			assign li = ent_idx[i-1];
			assign lv = ent_valid[i-1];
		end

		nnls_cell #(
			.DIST_BITS(DIST_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.cand_dist  (cand_dist),
			.cand_idx   (cand_idx),
			.left_ahead (lb),
			.left_dist  (ld),
			.left_idx   (li),
			.left_valid (lv),
			.right_dist (ent_dist[i+1]),
			.right_idx  (ent_idx[i+1]),
			.right_valid(ent_valid[i+1]),
			.ahead      (ahead[i]),
			.dist_q     (ent_dist[i]),
			.idx_q      (ent_idx[i]),
			.valid_q    (ent_valid[i])
		);
	end

	assign head_idx   = ent_idx[0];
	assign head_valid = ent_valid[0];

endmodule

[design/nearest_neighbor_list_select.sv]
// Nearest-neighbor list selector: top level with controller and two candidate chains.
//
// Usage: stream one distance-matrix element per transaction on elem_ch (row node,
// column node, distance, last-of-row mark). An element whose column equals its
// row is skipped; all others are inserted into two sorted chains, "any" and
// "non-depot" (never node 0), ordered by distance then lower index.
// Each element is inserted in the cycle it is accepted, so a row streams in at
// one element per cycle. The element that closes a row starts readout: one
// transaction per rank on rank_ch, rank 0 first, one per cycle while rank_ch is
// ready; ranks come from the chain heads as the chains shift toward cell 0.
// The first rank is offered the cycle after the closing element is accepted.
// elem_ch is held not ready during readout, so a new row waits until the
// last rank is taken. A stalled receiver freezes the readout in place.
// Depth is the requested depth, cut to the node count minus 2 when it is at
// least the node count, 0 when the node count is at most 1, and capped at
// LIST_DEPTH; at depth 0 the closing element only empties the chains.
// Reset empties both chains and zeros both configuration registers. The cfg
// channel is always ready and should be written only while the block is idle.
module nearest_neighbor_list_select #(
	parameter int LIST_DEPTH = 32,
	parameter int DIST_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	nnls_cfg_if.sink    cfg,
	nnls_in_if.sink     elem_ch,
	nnls_out_if.source  rank_ch
);

	localparam int CNT_W = $clog2(LIST_DEPTH + 1);

	nnls_pkg::state_t                 state_q;
	nnls_pkg::state_t                 state_d;
	logic [nnls_pkg::DEPTH_W-1:0]     req_depth_q;
	logic [nnls_pkg::COUNT_W-1:0]     nodes_q;
	logic [CNT_W-1:0]                 depth_q;
	logic [CNT_W-1:0]                 count_q;
	logic [nnls_pkg::NODE_W-1:0]      row_q;
	logic [nnls_pkg::COUNT_W-1:0]     lim_depth;
	logic [CNT_W-1:0]                 eff_depth;
	logic                             in_fire;
	logic                             out_fire;
	logic                             close_row;
	logic                             is_last;
	logic                             self_elem;
	nnls_pkg::cell_ctl_t              any_ctl;
	nnls_pkg::cell_ctl_t              nd_ctl;
	logic [nnls_pkg::NODE_W-1:0]      any_head_idx;
	logic                             any_head_valid;
	logic [nnls_pkg::NODE_W-1:0]      nd_head_idx;
	logic                             nd_head_valid;

	// Configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_depth_q <= '0;
			nodes_q     <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				nnls_pkg::REG_REQUESTED_DEPTH: req_depth_q <= cfg.data[nnls_pkg::DEPTH_W-1:0];
				nnls_pkg::REG_NODE_COUNT:      nodes_q     <= cfg.data[nnls_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective list depth
	always_comb begin
		if (nnls_pkg::COUNT_W'(req_depth_q) >= nodes_q) begin
			lim_depth = nodes_q - nnls_pkg::COUNT_W'(2);
		end else begin
			lim_depth = nnls_pkg::COUNT_W'(req_depth_q);
		end
		if (nodes_q <= nnls_pkg::COUNT_W'(1)) begin
			eff_depth = '0;
		end else if (lim_depth > nnls_pkg::COUNT_W'(LIST_DEPTH)) begin
			eff_depth = CNT_W'(LIST_DEPTH);
		end else begin
			eff_depth = CNT_W'(lim_depth);
		end
	end

	// Handshakes and chain control
	assign in_fire   = elem_ch.valid && elem_ch.ready;
	assign out_fire  = rank_ch.valid && rank_ch.ready;
	assign close_row = in_fire && elem_ch.last_in_row;
	assign is_last   = (count_q + CNT_W'(1)) == depth_q;
	assign self_elem = elem_ch.column_node == elem_ch.row_node;

	always_comb begin
		any_ctl.load  = in_fire && !self_elem;
		any_ctl.pop   = out_fire;
		any_ctl.clear = (close_row && (eff_depth == '0)) || (out_fire && is_last);
		nd_ctl        = any_ctl;
		nd_ctl.load   = any_ctl.load && (elem_ch.column_node != '0);
	end

	// Next state and handshake outputs
	always_comb begin
		state_d       = state_q;
		elem_ch.ready = 1'b0;
		rank_ch.valid = 1'b0;
		case (state_q)
			nnls_pkg::ST_IDLE: begin
				elem_ch.ready = 1'b1;
				if (close_row && (eff_depth != '0)) begin
					state_d = nnls_pkg::ST_EMIT;
				end
			end
			nnls_pkg::ST_EMIT: begin
				rank_ch.valid = 1'b1;
				if (out_fire && is_last) begin
					state_d = nnls_pkg::ST_IDLE;
				end
			end
			default: state_d = nnls_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nnls_pkg::ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (close_row) begin
				count_q <= '0;
			end else if (out_fire) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// Latch row node and depth of the closing element
	always_ff @(posedge clk) begin
		if (close_row) begin
			row_q   <= elem_ch.row_node;
			depth_q <= eff_depth;
		end
	end

	// Result payload from the chain heads
	assign rank_ch.list_node      = row_q;
	assign rank_ch.rank           = nnls_pkg::RANK_W'(count_q);
	assign rank_ch.near_any       = any_head_valid ? any_head_idx : '0;
	assign rank_ch.near_non_depot = nd_head_valid ? nd_head_idx : '0;
	assign rank_ch.last           = is_last;

	nnls_chain #(
		.DEPTH    (LIST_DEPTH),
		.DIST_BITS(DIST_BITS)
	) u_any_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (any_ctl),
		.cand_dist (elem_ch.distance),
		.cand_idx  (elem_ch.column_node),
		.head_idx  (any_head_idx),
		.head_valid(any_head_valid)
	);

	nnls_chain #(
		.DEPTH    (LIST_DEPTH),
		.DIST_BITS(DIST_BITS)
	) u_nd_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (nd_ctl),
		.cand_dist (elem_ch.distance),
		.cand_idx  (elem_ch.column_node),
		.head_idx  (nd_head_idx),
		.head_valid(nd_head_valid)
	);

endmodule

[bench/testbench.sv]
// Self-checking bench for the nearest-neighbor list selector: directed rows, then random rows.
module testbench;

	localparam int DIST_W      = 32;
	localparam int LIST_SLOTS  = 32;
	localparam int LIST_ANY    = 0;
	localparam int LIST_NONDEP = 1;
	localparam int IDLE_LIMIT  = 5000;
	localparam int SHOW_LIMIT  = 10;
	localparam int RANDOM_ITEMS = 100;

	// One matrix element, with an optional register update ahead of it and an
	// optional typed-in result set (n_typed < 0 means use the predictor)
	typedef struct packed {
		logic                           set_cfg;
		logic [nnls_pkg::DEPTH_W-1:0]   req;
		logic [nnls_pkg::COUNT_W-1:0]   nodes;
		logic [nnls_pkg::NODE_W-1:0]    row;
		logic [nnls_pkg::NODE_W-1:0]    col;
		logic [DIST_W-1:0]              dval;
		logic                           close;
		int                             n_typed;
		logic [nnls_pkg::NODE_W-1:0]    any0;
		logic [nnls_pkg::NODE_W-1:0]    nd0;
		logic [nnls_pkg::NODE_W-1:0]    any1;
		logic [nnls_pkg::NODE_W-1:0]    nd1;
	} step_t;

	typedef struct packed {
		logic [DIST_W-1:0]            dval;
		logic [nnls_pkg::NODE_W-1:0]  idx;
		logic                         used;
	} cand_t;

	typedef struct packed {
		logic [nnls_pkg::NODE_W-1:0]  list_node;
		logic [nnls_pkg::RANK_W-1:0]  rank;
		logic [nnls_pkg::NODE_W-1:0]  near_any;
		logic [nnls_pkg::NODE_W-1:0]  near_non_depot;
		logic                         last;
	} rank_entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	nnls_cfg_if                          cfg_bus ();
	nnls_in_if  #(.DIST_BITS(DIST_W))    elem_bus ();
	nnls_out_if                          rank_bus ();

	nearest_neighbor_list_select #(
		.LIST_DEPTH(LIST_SLOTS),
		.DIST_BITS (DIST_W)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.elem_ch(elem_bus),
		.rank_ch(rank_bus)
	);

	always #4 clk = ~clk;

	// Predictor state: both candidate lists and the two registers
	cand_t                        cand_lists [2][LIST_SLOTS];
	logic [nnls_pkg::DEPTH_W-1:0] depth_reg;
	logic [nnls_pkg::COUNT_W-1:0] count_reg;
	rank_entry_t                  ranks_due [$];

	bit steady;
	int mismatches;
	int ranks_checked;
	int elements_sent;
	int settings_used;
	int idle_cycles = 0;

	function automatic int draw_wait();
		if (steady)
			return 0;
		return $urandom_range(0, 17);
	endfunction

	function automatic void note_fault(input string msg);
		if (mismatches < SHOW_LIMIT)
			$display("MISMATCH: %s", msg);
		mismatches++;
	endfunction

	// Insert into one sorted list: distance first, lower index breaks ties
	function automatic void place_candidate(input int which, input logic [DIST_W-1:0] d,
			input logic [nnls_pkg::NODE_W-1:0] idx);
		int pos;
		pos = LIST_SLOTS;
		for (int i = 0; i < LIST_SLOTS; i++) begin
			if (!cand_lists[which][i].used || d < cand_lists[which][i].dval ||
					(d == cand_lists[which][i].dval && idx < cand_lists[which][i].idx)) begin
				pos = i;
				break;
			end
		end
		if (pos < LIST_SLOTS) begin
			for (int i = LIST_SLOTS - 1; i > pos; i--)
				cand_lists[which][i] = cand_lists[which][i-1];
			cand_lists[which][pos] = '{dval: d, idx: idx, used: 1'b1};
		end
	endfunction

	function automatic int list_depth();
		int d;
		d = int'(depth_reg);
		if (count_reg <= 1)
			return 0;
		if (d >= int'(count_reg))
			d = int'(count_reg) - 2;
		if (d > LIST_SLOTS)
			d = LIST_SLOTS;
		return d;
	endfunction

	// Apply one accepted element; on a row close, queue the ranks and empty the lists
	function automatic void take_element(input step_t s, input bit record);
		int depth;
		rank_entry_t r;
		if (s.col != s.row) begin
			place_candidate(LIST_ANY, s.dval, s.col);
			if (s.col != '0)
				place_candidate(LIST_NONDEP, s.dval, s.col);
		end
		if (!s.close)
			return;
		depth = list_depth();
		for (int k = 0; k < depth && record; k++) begin
			r.list_node      = s.row;
			r.rank           = k[nnls_pkg::RANK_W-1:0];
			r.near_any       = cand_lists[LIST_ANY][k].used ? cand_lists[LIST_ANY][k].idx : '0;
			r.near_non_depot = cand_lists[LIST_NONDEP][k].used ?
				cand_lists[LIST_NONDEP][k].idx : '0;
			r.last           = (k + 1 == depth);
			ranks_due.push_back(r);
		end
		for (int i = 0; i < LIST_SLOTS; i++) begin
			cand_lists[LIST_ANY][i]    = '0;
			cand_lists[LIST_NONDEP][i] = '0;
		end
	endfunction

	// Drive one element, wait for its transaction, then record what it causes
	task automatic push_element(input step_t s);
		int gap;
		rank_entry_t r;
		gap = draw_wait();
		if (gap > 0) begin
			elem_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		elem_bus.row_node    = s.row;
		elem_bus.column_node = s.col;
		elem_bus.distance    = s.dval;
		elem_bus.last_in_row = s.close;
		elem_bus.valid       = 1'b1;
		do @(posedge clk); while (!elem_bus.ready);
		take_element(s, s.n_typed < 0);
		for (int k = 0; k < s.n_typed; k++) begin
			r.list_node      = s.row;
			r.rank           = k[nnls_pkg::RANK_W-1:0];
			r.near_any       = (k == 0) ? s.any0 : s.any1;
			r.near_non_depot = (k == 0) ? s.nd0 : s.nd1;
			r.last           = (k + 1 == s.n_typed);
			ranks_due.push_back(r);
		end
		elements_sent++;
		@(negedge clk);
	endtask

	// Hold the stream until every queued rank has come back, then let the block settle
	task automatic settle();
		elem_bus.valid = 1'b0;
		while (ranks_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input nnls_pkg::cfg_reg_t idx,
			input logic [nnls_pkg::CFG_DATA_W-1:0] value);
		cfg_bus.index = idx;
		cfg_bus.data  = value;
		cfg_bus.valid = 1'b1;
		do @(posedge clk); while (!cfg_bus.ready);
		if (idx == nnls_pkg::REG_REQUESTED_DEPTH)
			depth_reg = value[nnls_pkg::DEPTH_W-1:0];
		else if (idx == nnls_pkg::REG_NODE_COUNT)
			count_reg = value[nnls_pkg::COUNT_W-1:0];
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	task automatic apply_setting(input logic [nnls_pkg::DEPTH_W-1:0] req,
			input logic [nnls_pkg::COUNT_W-1:0] nodes, input logic [4:0] spare);
		settle();
		write_reg(nnls_pkg::REG_REQUESTED_DEPTH, {spare, req});
		write_reg(nnls_pkg::REG_NODE_COUNT, nodes);
		settings_used++;
	endtask

	// Accept ranks with random stalls and compare them against the queue head
	initial begin : rank_sink
		int stall;
		rank_entry_t want;
		rank_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				rank_bus.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rank_bus.ready = 1'b1;
			do @(posedge clk); while (!rank_bus.valid);
			ranks_checked++;
			if (ranks_due.size() == 0) begin
				note_fault($sformatf("unexpected rank: node %0d rank %0d any %0d nondepot %0d last %0d",
					rank_bus.list_node, rank_bus.rank, rank_bus.near_any,
					rank_bus.near_non_depot, rank_bus.last));
			end else begin
				want = ranks_due.pop_front();
				if (rank_bus.list_node !== want.list_node || rank_bus.rank !== want.rank ||
						rank_bus.near_any !== want.near_any ||
						rank_bus.near_non_depot !== want.near_non_depot ||
						rank_bus.last !== want.last)
					note_fault($sformatf({"exp node %0d rank %0d any %0d nondepot %0d last %0d, ",
						"got node %0d rank %0d any %0d nondepot %0d last %0d"},
						want.list_node, want.rank, want.near_any, want.near_non_depot, want.last,
						rank_bus.list_node, rank_bus.rank, rank_bus.near_any,
						rank_bus.near_non_depot, rank_bus.last));
			end
			@(negedge clk);
		end
	end

	// End the run when no channel has moved a transaction for too long
	always @(posedge clk) begin
		if ((elem_bus.valid && elem_bus.ready) || (rank_bus.valid && rank_bus.ready) ||
				(cfg_bus.valid && cfg_bus.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : stimulus
		step_t plan [$];
		step_t s;
		int phase;
		int random_items;
		int rows;
		int kind;
		int len;
		int span;
		int base;
		bit ties;
		int req;
		int nodes;

		cfg_bus.valid = 1'b0;
		cfg_bus.index = nnls_pkg::REG_REQUESTED_DEPTH;
		cfg_bus.data  = '0;
		elem_bus.valid       = 1'b0;
		elem_bus.row_node    = '0;
		elem_bus.column_node = '0;
		elem_bus.distance    = '0;
		elem_bus.last_in_row = 1'b0;
		mismatches = 0;
		ranks_checked = 0;
		elements_sent = 0;
		settings_used = 0;
		random_items = 0;
		steady = 1'b0;
		depth_reg = '0;
		count_reg = '0;
		for (int i = 0; i < LIST_SLOTS; i++) begin
			cand_lists[LIST_ANY][i]    = '0;
			cand_lists[LIST_NONDEP][i] = '0;
		end

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed rows: set_cfg req nodes | row col dist close | typed count, rank 0/1 lists
		// Registers still at reset: node count 0 gives no ranks
		plan.push_back('{0, 0, 0,    3, 1, 5, 1,    0, 0, 0, 0, 0});
		// Depth 2 of 8 nodes: self skipped, field extremes, nearest first
		plan.push_back('{1, 2, 8,    0, 0, 0, 0,    0, 0, 0, 0, 0});
		plan.push_back('{0, 0, 0,    0, 1023, 32'hFFFF_FFFF, 0,    0, 0, 0, 0, 0});
		plan.push_back('{0, 0, 0,    0, 5, 0, 1,    2, 5, 5, 1023, 1023});
		// Equal distances: lower index wins, depot kept out of the second list
		plan.push_back('{0, 0, 0,    7, 0, 10, 0,    0, 0, 0, 0, 0});
		plan.push_back('{0, 0, 0,    7, 3, 10, 0,    0, 0, 0, 0, 0});
		plan.push_back('{0, 0, 0,    7, 2, 10, 1,    2, 0, 2, 2, 3});
		// Self element closing an empty row: all slots unfilled
		plan.push_back('{0, 0, 0,    1, 1, 0, 1,    2, 0, 0, 0, 0});
		// Depot only: non-depot list stays empty
		plan.push_back('{0, 0, 0,    2, 0, 4, 1,    2, 0, 0, 0, 0});
		// Duplicate column with equal distance takes two slots
		plan.push_back('{0, 0, 0,    4, 6, 9, 0,    0, 0, 0, 0, 0});
		plan.push_back('{0, 0, 0,    4, 6, 9, 1,    2, 6, 6, 6, 6});
		// Requested depth at or above node count is cut to node count - 2
		plan.push_back('{1, 5, 4,    2, 3, 1, 1,    2, 3, 3, 0, 0});
		// One node: nothing emitted
		plan.push_back('{1, 0, 1,    1023, 1022, 7, 1,    0, 0, 0, 0, 0});
		// Largest register values: depth saturates to the list size
		plan.push_back('{1, 63, 2047,    1023, 0, 1, 0,    -1, 0, 0, 0, 0});
		plan.push_back('{0, 0, 0,    1023, 1023, 0, 0,    -1, 0, 0, 0, 0});
		plan.push_back('{0, 0, 0,    1023, 512, 32'hFFFF_FFFF, 0,    -1, 0, 0, 0, 0});
		plan.push_back('{0, 0, 0,    1023, 1, 1, 1,    -1, 0, 0, 0, 0});
		// Two nodes, depth 1, then depth 2 of 2 nodes cut to zero
		plan.push_back('{1, 1, 2,    1, 0, 3, 0,    -1, 0, 0, 0, 0});
		plan.push_back('{0, 0, 0,    1, 1, 0, 1,    -1, 0, 0, 0, 0});
		plan.push_back('{1, 2, 2,    0, 1, 2, 1,    0, 0, 0, 0, 0});

		foreach (plan[i]) begin
			if (plan[i].set_cfg)
				apply_setting(plan[i].req, plan[i].nodes, 5'd0);
			push_element(plan[i]);
		end

		// Random phases: a fresh setting each, mostly well-formed rows
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: begin
					req = 63;
					nodes = 2047;
				end
				1: begin
					req = $urandom_range(0, 63);
					nodes = $urandom_range(0, 1);
				end
				2: begin
					nodes = $urandom_range(2, 12);
					req = $urandom_range(nodes, 63);
				end
				3: begin
					req = 0;
					nodes = $urandom_range(2, 1024);
				end
				4: begin
					req = 32;
					nodes = $urandom_range(33, 1024);
				end
				default: begin
					req = $urandom_range(1, 8);
					nodes = $urandom_range(4, 40);
				end
			endcase
			// First phase overfills the lists with a long row
			if (phase == 0) begin
				req = 32;
				nodes = 40;
			end
			apply_setting(nnls_pkg::DEPTH_W'(req), nnls_pkg::COUNT_W'(nodes),
				5'($urandom_range(0, 31)));
			steady = ($urandom_range(0, 3) == 0);
			span = (nodes >= 2 && nodes <= 1024) ? nodes : 24;
			rows = (phase == 0) ? 1 : $urandom_range(1, 3);
			for (int r = 0; r < rows; r++) begin
				kind = $urandom_range(0, 9);
				len = (phase == 0) ? 40 : $urandom_range(1, (span < 12) ? span : 12);
				ties = ($urandom_range(0, 2) == 0);
				base = $urandom_range(0, span - 1);
				for (int j = 0; j < len; j++) begin
					s = '0;
					s.n_typed = -1;
					s.close = (j == len - 1);
					if (kind < 7) begin
						// Well-formed row: every column once, row node fixed
						s.row = nnls_pkg::NODE_W'(base);
						s.col = nnls_pkg::NODE_W'(j);
						s.dval = ties ? DIST_W'($urandom_range(0, 3) * 256) : $urandom;
					end else if (kind < 9) begin
						// Noise: any field anywhere, rows closing at random
						s.row = nnls_pkg::NODE_W'($urandom_range(0, 1023));
						s.col = nnls_pkg::NODE_W'($urandom_range(0, 1023));
						s.dval = $urandom;
						s.close = s.close || ($urandom_range(0, 5) == 0);
					end else begin
						// Broken row: mixed row nodes, duplicates, columns past the count
						s.row = nnls_pkg::NODE_W'(base + $urandom_range(0, 1));
						s.col = nnls_pkg::NODE_W'($urandom_range(0, span + 3));
						s.dval = DIST_W'($urandom_range(0, 7));
					end
					push_element(s);
					random_items++;
				end
			end
			phase++;
		end

		// Drain and let the readout finish
		elem_bus.valid = 1'b0;
		steady = 1'b0;
		while (ranks_due.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (ranks_due.size() != 0)
			note_fault($sformatf("%0d ranks never arrived", ranks_due.size()));

		$display("Covered %0d matrix elements under %0d register settings, %0d ranks compared",
			elements_sent, settings_used, ranks_checked);
		$display("Mismatches counted: %0d", mismatches);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
